// ===== src/mrfc_pkg.sv =====
// ----------------------------------------------------------------------------
// mrfc_pkg: shared types and constants of the request frame checker
// Holds the request classification passed from the front end to the back
// end, the result record and the frame layout constants.
// ----------------------------------------------------------------------------
package mrfc_pkg;

    // Frame layout
    localparam int unsigned FRAME_LEN   = 11;
    localparam int unsigned DATA_LEN    = 9;
    localparam int unsigned HEADER_LEN  = 5;
    localparam int unsigned IDX_W       = 4;
    localparam int unsigned SLOT_W      = 3;

    // CRC-16, reflected form
    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'hA001;

    // Raw codes of the switch and mode bytes
    localparam logic [7:0]  RAW_CODE_A  = 8'h01;
    localparam logic [7:0]  RAW_CODE_B  = 8'h02;

    // Decoded codes of the switch and mode fields
    localparam logic [1:0]  DEC_CODE_A  = 2'd0;
    localparam logic [1:0]  DEC_CODE_B  = 2'd1;
    localparam logic [1:0]  DEC_NONE    = 2'd2;

    // Where a byte lands in the frame
    typedef enum logic [1:0] {
        KIND_HEADER,
        KIND_INTERVAL,
        KIND_CHECK,
        KIND_IGNORE
    } byte_kind_t;

    // One classified byte, front end to back end
    typedef struct packed {
        logic [7:0]        rx_byte;
        byte_kind_t        kind;
        logic [SLOT_W-1:0] slot;
        logic              last;
        logic              short_frame;
    } op_t;

    // One frame result
    typedef struct packed {
        logic        crc_ok;
        logic        short_frame;
        logic [7:0]  slave_address;
        logic [7:0]  function_code;
        logic [1:0]  read_switch;
        logic [1:0]  run_mode;
        logic [7:0]  antenna_select;
        logic [31:0] read_interval;
        logic [15:0] crc_value;
    } result_t;

endpackage

// ===== src/mrfc_fifo.sv =====
// ----------------------------------------------------------------------------
// mrfc_fifo: small register queue
// First-in first-out store of WIDTH-bit entries, DEPTH deep (at least 2).
// Full and empty come straight from the fill count.
// ----------------------------------------------------------------------------
module mrfc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // Pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== src/mrfc_front.sv =====
// ----------------------------------------------------------------------------
// mrfc_front: byte intake and classification
// Counts the bytes of the current frame (saturating past the last check
// byte) and tags each request with its role in the frame.
// ----------------------------------------------------------------------------
module mrfc_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     rx_byte,
    input  logic           frame_end,
    output logic           full,
    output logic           op_push,
    output mrfc_pkg::op_t  op,
    input  logic           op_full
);

    import mrfc_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;

    assign full    = op_full;
    assign op_push = push && !op_full;

    // Classify the byte by its place in the frame
    always_comb
    begin
        op.rx_byte     = rx_byte;
        op.last        = frame_end;
        op.slot        = byte_index_reg[SLOT_W-1:0];
        // a frame that ends here is short when it holds fewer than FRAME_LEN bytes
        op.short_frame = (byte_index_reg < IDX_W'(FRAME_LEN - 1));
        if (byte_index_reg < IDX_W'(HEADER_LEN))
        begin
            op.kind = KIND_HEADER;
        end
        else if (byte_index_reg < IDX_W'(DATA_LEN))
        begin
            op.kind = KIND_INTERVAL;
        end
        else if (byte_index_reg < IDX_W'(FRAME_LEN))
        begin
            op.kind = KIND_CHECK;
        end
        else
        begin
            op.kind = KIND_IGNORE;
        end
    end

    // Byte counter, cleared at frame end
    always_comb
    begin
        byte_index_next = byte_index_reg;
        if (op_push)
        begin
            if (frame_end)
            begin
                byte_index_next = '0;
            end
            else if (byte_index_reg < IDX_W'(FRAME_LEN))
            begin
                byte_index_next = byte_index_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= '0;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
        end
    end

endmodule

// ===== src/mrfc_back.sv =====
// ----------------------------------------------------------------------------
// mrfc_back: CRC engine and field capture
// Takes one classified byte per cycle while one is queued and not held,
// runs the bytewise CRC-16 update, captures header, interval and check
// bytes, and builds the frame result on the last byte of a frame.
// ----------------------------------------------------------------------------
module mrfc_back (
    input  logic               clk,
    input  logic               rst_n,
    input  mrfc_pkg::op_t      op,
    input  logic               op_empty,
    output logic               op_pop,
    output logic               res_push,
    output mrfc_pkg::result_t  res,
    input  logic               res_full
);

    import mrfc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [7:0]  header_reg [HEADER_LEN];
    logic [7:0]  header_next [HEADER_LEN];
    logic [31:0] interval_reg, interval_next;
    logic [15:0] check_reg, check_next;
    logic [15:0] crc_upd;
    logic        take;

    // Bytewise reflected CRC-16 update
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    function automatic logic [1:0] decode_code(input logic [7:0] b);
        logic [1:0] d;
        if (b == RAW_CODE_A)
        begin
            d = DEC_CODE_A;
        end
        else if (b == RAW_CODE_B)
        begin
            d = DEC_CODE_B;
        end
        else
        begin
            d = DEC_NONE;
        end
        return d;
    endfunction

    // A last byte waits until the result queue has room
    assign take     = !op_empty && (!op.last || !res_full);
    assign op_pop   = take;
    assign res_push = take && op.last;
    assign crc_upd  = crc_byte(crc_reg, op.rx_byte);

    // Next state of the frame registers
    always_comb
    begin
        crc_next      = crc_reg;
        interval_next = interval_reg;
        check_next    = check_reg;
        for (int i = 0; i < HEADER_LEN; i++)
        begin
            header_next[i] = header_reg[i];
        end
        case (op.kind)
            KIND_HEADER:
            begin
                crc_next = crc_upd;
                for (int i = 0; i < HEADER_LEN; i++)
                begin
                    if (op.slot == SLOT_W'(i))
                    begin
                        header_next[i] = op.rx_byte;
                    end
                end
            end
            KIND_INTERVAL:
            begin
                crc_next      = crc_upd;
                interval_next = {interval_reg[23:0], op.rx_byte};
            end
            KIND_CHECK:
            begin
                check_next = {check_reg[7:0], op.rx_byte};
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
    end

    // Frame result from the updated registers
    always_comb
    begin
        res.crc_value   = crc_next;
        res.short_frame = op.short_frame;
        if (op.short_frame)
        begin
            res.crc_ok         = 1'b0;
            res.slave_address  = '0;
            res.function_code  = '0;
            res.read_switch    = '0;
            res.run_mode       = '0;
            res.antenna_select = '0;
            res.read_interval  = '0;
        end
        else
        begin
            res.crc_ok         = (crc_next == check_next);
            res.slave_address  = header_next[0];
            res.function_code  = header_next[1];
            res.read_switch    = decode_code(header_next[2]);
            res.run_mode       = decode_code(header_next[3]);
            res.antenna_select = header_next[4];
            res.read_interval  = interval_next;
        end
    end

    // CRC register restarts after every frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg <= CRC_INIT;
        end
        else if (take)
        begin
            crc_reg <= op.last ? CRC_INIT : crc_next;
        end
    end

    // Captured bytes keep their value across frames
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            interval_reg <= interval_next;
            check_reg    <= check_next;
            for (int i = 0; i < HEADER_LEN; i++)
            begin
                header_reg[i] <= header_next[i];
            end
        end
    end

endmodule

// ===== src/modbus_request_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// modbus_request_frame_checker_core: 11-byte request frame checker
// Checks the CRC-16 of fixed-length serial request frames and decodes
// their fields.
// ----------------------------------------------------------------------------
// The block takes one received byte per clock while full is low and
// delivers one result per frame, on the byte flagged frame_end. Throughput
// is one byte request per cycle unless stalled, set by the bytewise CRC-16
// update in the back end, which handles one byte each cycle unless held.
// With both queues empty, a frame's last byte is registered in the byte
// queue between front end and back end, then its result in the result
// queue, showing on the output ports as soon as it enters. The byte queue
// holds OP_DEPTH requests and the result queue RES_DEPTH results; when the
// result queue is full the back end holds the last byte of a frame and the
// byte queue fills, raising full. Result fields other than crc_value are
// valid only when crc_ok is 1; for a short frame they read zero.
module modbus_request_frame_checker_core #(
    parameter int unsigned OP_DEPTH  = 2,
    parameter int unsigned RES_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    input  logic        frame_end,
    output logic        empty,
    input  logic        pop,
    output logic        crc_ok,
    output logic        short_frame,
    output logic [7:0]  slave_address,
    output logic [7:0]  function_code,
    output logic [1:0]  read_switch,
    output logic [1:0]  run_mode,
    output logic [7:0]  antenna_select,
    output logic [31:0] read_interval,
    output logic [15:0] crc_value
);

    import mrfc_pkg::*;

    op_t     front_op, back_op;
    logic    op_push, op_full, op_pop, op_empty;
    result_t back_res, out_res;
    logic    res_push, res_full;

    // Byte intake and classification
    mrfc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .frame_end (frame_end),
        .full      (full),
        .op_push   (op_push),
        .op        (front_op),
        .op_full   (op_full)
    );

    // Queue of classified bytes
    mrfc_fifo #(
        .WIDTH ($bits(op_t)),
        .DEPTH (OP_DEPTH)
    ) u_op_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .wdata (front_op),
        .full  (op_full),
        .pop   (op_pop),
        .rdata (back_op),
        .empty (op_empty)
    );

    // CRC engine and field capture
    mrfc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_empty (op_empty),
        .op_pop   (op_pop),
        .res_push (res_push),
        .res      (back_res),
        .res_full (res_full)
    );

    // Result queue facing the consumer
    mrfc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RES_DEPTH)
    ) u_res_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (back_res),
        .full  (res_full),
        .pop   (pop),
        .rdata (out_res),
        .empty (empty)
    );

    assign crc_ok         = out_res.crc_ok;
    assign short_frame    = out_res.short_frame;
    assign slave_address  = out_res.slave_address;
    assign function_code  = out_res.function_code;
    assign read_switch    = out_res.read_switch;
    assign run_mode       = out_res.run_mode;
    assign antenna_select = out_res.antenna_select;
    assign read_interval  = out_res.read_interval;
    assign crc_value      = out_res.crc_value;

endmodule

// ===== src/mrfc_checker.sv =====
// ----------------------------------------------------------------------------
// mrfc_checker: port-level assertions for the frame checker
// Watches the top level's ports and flags results that break the
// frame rules or a result queue that loses its head.
// ----------------------------------------------------------------------------
module mrfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic        crc_ok,
    input logic        short_frame,
    input logic [7:0]  slave_address,
    input logic [7:0]  function_code,
    input logic [1:0]  read_switch,
    input logic [1:0]  run_mode,
    input logic [7:0]  antenna_select,
    input logic [31:0] read_interval,
    input logic [15:0] crc_value
);

    import mrfc_pkg::*;

    // A short frame never passes the CRC check
    a_short_no_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && short_frame) |-> !crc_ok)
        else $error("short frame reported with crc_ok");

    // A short frame reports zero fields
    a_short_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && short_frame) |-> (slave_address == '0 && function_code == '0
            && read_switch == '0 && run_mode == '0 && antenna_select == '0
            && read_interval == '0))
        else $error("short frame reported with nonzero fields");

    // Decoded fields only take their defined codes
    a_decode_range: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((read_switch == DEC_CODE_A || read_switch == DEC_CODE_B
            || read_switch == DEC_NONE) && (run_mode == DEC_CODE_A
            || run_mode == DEC_CODE_B || run_mode == DEC_NONE)))
        else $error("undefined switch or mode code");

    // A result not taken stays in place
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(crc_value) && $stable(crc_ok)))
        else $error("waiting result lost or changed");

endmodule

bind modbus_request_frame_checker_core mrfc_checker u_mrfc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .crc_ok         (crc_ok),
    .short_frame    (short_frame),
    .slave_address  (slave_address),
    .function_code  (function_code),
    .read_switch    (read_switch),
    .run_mode       (run_mode),
    .antenna_select (antenna_select),
    .read_interval  (read_interval),
    .crc_value      (crc_value)
);

// ===== dv/tb_modbus_request_frame_checker_core.sv =====
// ----------------------------------------------------------------------------
// tb_modbus_request_frame_checker_core: request frame checker testbench
// Sends byte streams of 11-byte request frames (good, bad check, short and
// long) through the byte queue, predicts each frame result, and checks every
// result popped from the result queue against the prediction in order.
// ----------------------------------------------------------------------------
module tb_modbus_request_frame_checker_core;

    import mrfc_pkg::*;

    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned PHASE_BYTES  = 500;
    localparam int unsigned TAIL_CYCLES  = 20;

    typedef logic [7:0] frame_q_t[$];

    typedef enum logic [1:0] {
        FK_GOOD,
        FK_BAD_CHECK,
        FK_SHORT,
        FK_LONG
    } frame_kind_t;

    // Frame result predictor and in-order result checker
    class frame_scoreboard;
        result_t     expected_q[$];
        logic [3:0]  idx;
        logic [15:0] crc;
        logic [7:0]  hdr[HEADER_LEN];
        logic [31:0] ival;
        logic [15:0] chk;
        int          errors;
        int          n_checked;

        function new();
            idx  = '0;
            crc  = CRC_INIT;
            ival = '0;
            chk  = '0;
            foreach (hdr[i]) hdr[i] = '0;
            errors    = 0;
            n_checked = 0;
        endfunction

        // Reflected CRC-16, one byte
        static function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
            logic [15:0] r;
            r = c ^ {8'h00, b};
            for (int k = 0; k < 8; k++)
                r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
            return r;
        endfunction

        static function logic [1:0] decode_code(logic [7:0] b);
            if (b == RAW_CODE_A) return DEC_CODE_A;
            if (b == RAW_CODE_B) return DEC_CODE_B;
            return DEC_NONE;
        endfunction

        // Accepted byte request: update frame state, predict on frame end
        function void note_byte(logic [7:0] b, logic last);
            result_t r;
            if (idx < FRAME_LEN) begin
                if (idx < DATA_LEN) begin
                    crc = crc16_byte(crc, b);
                    if (idx < HEADER_LEN)
                        hdr[idx] = b;
                    else
                        ival = {ival[23:0], b};
                end else begin
                    chk = {chk[7:0], b};
                end
                idx++;
            end
            if (last) begin
                r = '0;
                if (idx < FRAME_LEN) begin
                    r.short_frame = 1'b1;
                end else begin
                    r.crc_ok         = (crc == chk);
                    r.slave_address  = hdr[0];
                    r.function_code  = hdr[1];
                    r.read_switch    = decode_code(hdr[2]);
                    r.run_mode       = decode_code(hdr[3]);
                    r.antenna_select = hdr[4];
                    r.read_interval  = ival;
                end
                r.crc_value = crc;
                expected_q.push_back(r);
                idx = '0;
                crc = CRC_INIT;
            end
        endfunction

        function void cmp_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0h, got %0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Popped result: compare with the oldest prediction
        function void check_result(result_t got);
            result_t w;
            if (expected_q.size() == 0) begin
                $error("result popped with none expected");
                errors++;
                return;
            end
            w = expected_q.pop_front();
            n_checked++;
            cmp_field("crc_ok",         w.crc_ok,         got.crc_ok);
            cmp_field("short_frame",    w.short_frame,    got.short_frame);
            cmp_field("slave_address",  w.slave_address,  got.slave_address);
            cmp_field("function_code",  w.function_code,  got.function_code);
            cmp_field("read_switch",    w.read_switch,    got.read_switch);
            cmp_field("run_mode",       w.run_mode,       got.run_mode);
            cmp_field("antenna_select", w.antenna_select, got.antenna_select);
            cmp_field("read_interval",  w.read_interval,  got.read_interval);
            cmp_field("crc_value",      w.crc_value,      got.crc_value);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic [7:0]  rx_byte;
    logic        frame_end;
    logic        empty;
    logic        pop;
    logic        crc_ok;
    logic        short_frame;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [1:0]  read_switch;
    logic [1:0]  run_mode;
    logic [7:0]  antenna_select;
    logic [31:0] read_interval;
    logic [15:0] crc_value;

    frame_scoreboard sb;
    result_t         seen;
    int unsigned     tx_idle_pct;
    int unsigned     rx_idle_pct;
    int unsigned     hold_req_cnt;
    int unsigned     hold_seen;
    int unsigned     hold_left;
    int unsigned     cycles;
    int unsigned     n_bytes;
    int unsigned     kind_cnt[4];

    modbus_request_frame_checker_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .rx_byte        (rx_byte),
        .frame_end      (frame_end),
        .empty          (empty),
        .pop            (pop),
        .crc_ok         (crc_ok),
        .short_frame    (short_frame),
        .slave_address  (slave_address),
        .function_code  (function_code),
        .read_switch    (read_switch),
        .run_mode       (run_mode),
        .antenna_select (antenna_select),
        .read_interval  (read_interval),
        .crc_value      (crc_value)
    );

    // Clock
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: random pop, with a long hold-off on request
    initial
    begin
        forever begin
            @(negedge clk);
            if (hold_seen != hold_req_cnt) begin
                hold_seen = hold_req_cnt;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                pop = 1'b0;
                hold_left--;
            end else begin
                pop = ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // Result monitor
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty) begin
            seen = '{crc_ok, short_frame, slave_address, function_code, read_switch,
                     run_mode, antenna_select, read_interval, crc_value};
            sb.check_result(seen);
        end
    end

    // Append the check bytes, high byte first, over the first nine bytes
    function automatic frame_q_t append_check(frame_q_t f);
        logic [15:0] c;
        c = CRC_INIT;
        for (int i = 0; i < DATA_LEN; i++)
            c = frame_scoreboard::crc16_byte(c, f[i]);
        f.push_back(c[15:8]);
        f.push_back(c[7:0]);
        return f;
    endfunction

    function automatic logic [7:0] rand_code();
        int unsigned p;
        p = $urandom_range(99);
        if (p < 40) return RAW_CODE_A;
        if (p < 80) return RAW_CODE_B;
        return 8'($urandom_range(255));
    endfunction

    function automatic frame_q_t make_frame(frame_kind_t kind);
        frame_q_t    f;
        int unsigned len;
        int unsigned pos;
        for (int i = 0; i < DATA_LEN; i++)
            f.push_back((i == 2 || i == 3) ? rand_code() : 8'($urandom_range(255)));
        f = append_check(f);
        case (kind)
            FK_BAD_CHECK:
            begin
                pos = DATA_LEN + $urandom_range(1);
                f[pos] = f[pos] ^ (8'h01 << $urandom_range(7));
            end
            FK_SHORT:
            begin
                len = $urandom_range(FRAME_LEN - 1, 1);
                while (f.size() > len) void'(f.pop_back());
            end
            FK_LONG:
            begin
                repeat ($urandom_range(5, 1)) f.push_back(8'($urandom_range(255)));
            end
            default: ;
        endcase
        return f;
    endfunction

    // One byte request; returns once it is accepted
    task automatic send_byte(input logic [7:0] b, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            push = 1'b0;
            @(negedge clk);
        end
        push      = 1'b1;
        rx_byte   = b;
        frame_end = last;
        @(posedge clk);
        while (full) @(posedge clk);
        sb.note_byte(b, last);
        n_bytes++;
    endtask

    task automatic send_frame(input frame_q_t f, input frame_kind_t kind);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
        kind_cnt[kind]++;
    endtask

    // Stop sending and wait for every predicted result
    task automatic wait_drained();
        @(negedge clk);
        push = 1'b0;
        while (sb.pending() != 0) @(posedge clk);
    endtask

    task automatic run_random(input int unsigned n);
        int unsigned start;
        int unsigned p;
        frame_kind_t kind;
        start = n_bytes;
        while (n_bytes - start < n) begin
            p = $urandom_range(99);
            if (p < 70)      kind = FK_GOOD;
            else if (p < 80) kind = FK_BAD_CHECK;
            else if (p < 90) kind = FK_SHORT;
            else             kind = FK_LONG;
            send_frame(make_frame(kind), kind);
        end
    endtask

    // Main sequence
    initial
    begin
        frame_q_t f;
        clk          = 1'b0;
        rst_n        = 1'b0;
        push         = 1'b0;
        pop          = 1'b0;
        rx_byte      = '0;
        frame_end    = 1'b0;
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_req_cnt = 0;
        hold_seen    = 0;
        hold_left    = 0;
        cycles       = 0;
        n_bytes      = 0;
        foreach (kind_cnt[i]) kind_cnt[i] = 0;
        sb = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: good frame with extreme fields
        f = '{8'h00, 8'hFF, RAW_CODE_A, RAW_CODE_B, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_frame(append_check(f), FK_GOOD);
        // Single-byte short frame
        f = '{8'hA5};
        send_frame(f, FK_SHORT);
        // Long frame with a corrupted check byte and trailing bytes
        f = '{8'hFF, 8'h00, RAW_CODE_B, RAW_CODE_A, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00};
        f = append_check(f);
        f[FRAME_LEN - 1] = f[FRAME_LEN - 1] ^ 8'h01;
        f.push_back(8'h5A);
        f.push_back(8'hC3);
        send_frame(f, FK_LONG);
        wait_drained();

        // Sender mostly busy, receiver mostly idle
        tx_idle_pct = 17;
        rx_idle_pct = 78;
        run_random(PHASE_BYTES);
        wait_drained();

        // Sender mostly idle, receiver mostly busy
        tx_idle_pct = 78;
        rx_idle_pct = 17;
        run_random(PHASE_BYTES);
        wait_drained();

        // Full rate, with one long output stall to back up both queues
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req_cnt++;
        run_random(PHASE_BYTES);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d bytes in %0d frames: %0d good, %0d bad check, %0d short, %0d long",
                 n_bytes, kind_cnt[FK_GOOD] + kind_cnt[FK_BAD_CHECK] + kind_cnt[FK_SHORT]
                 + kind_cnt[FK_LONG], kind_cnt[FK_GOOD], kind_cnt[FK_BAD_CHECK],
                 kind_cnt[FK_SHORT], kind_cnt[FK_LONG]);
        $display("Checked %0d results under three idle profiles and one long output stall",
                 sb.n_checked);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/mrfc_pkg.sv
src/mrfc_fifo.sv
src/mrfc_front.sv
src/mrfc_back.sv
src/modbus_request_frame_checker_core.sv
src/mrfc_checker.sv
dv/tb_modbus_request_frame_checker_core.sv
